FILE: rtl/core/lefe_pkg.sv
// Package: constants, types and helpers for the LED effect frame encoder.
package lefe_pkg;

  localparam int MaxLedsDef = 64;

  localparam logic [2:0] ModeBlink   = 3'd1;
  localparam logic [2:0] ModeWipe    = 3'd2;
  localparam logic [2:0] ModeBreath  = 3'd3;
  localparam logic [2:0] ModeRainbow = 3'd4;
  localparam logic [2:0] ModeChase   = 3'd5;

  localparam logic [2:0] RegMode   = 3'd0;
  localparam logic [2:0] RegColor  = 3'd1;
  localparam logic [2:0] RegStep   = 3'd2;
  localparam logic [2:0] RegLength = 3'd3;
  localparam logic [2:0] RegBright = 3'd4;

  localparam logic [2:0] CodeOne  = 3'h6;
  localparam logic [2:0] CodeZero = 3'h4;

  // one start request from the sequencer to the shared scaler
  typedef struct packed {
    logic        start;
    logic [23:0] rgb;
    logic [7:0]  bright;
  } scale_req_t;

  function automatic logic [23:0] encode_byte(input logic [7:0] v);
    logic [23:0] bits;
    bits = '0;
    for (int i = 7; i >= 0; i--) begin
      bits = {bits[20:0], (v[i] ? CodeOne : CodeZero)};
    end
    return bits;
  endfunction

  function automatic logic [23:0] wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] q;
    p = 8'd255 - pos;
    if (p < 8'd85) begin
      q = 8'(p * 3);
      return {8'd255 - q, 8'd0, q};
    end else if (p < 8'd170) begin
      q = 8'((p - 8'd85) * 3);
      return {8'd0, q, 8'd255 - q};
    end else begin
      q = 8'((p - 8'd170) * 3);
      return {q, 8'd255 - q, 8'd0};
    end
  endfunction

endpackage

FILE: rtl/core/lefe_scale.sv
// Shared colour scaler: three channels in one pass, x*b/255 with a small correction.
module lefe_scale
  import lefe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  scale_req_t req,
  output logic       done,
  output logic [23:0] result
);

  logic [1:0]  chan;
  logic        busy;
  logic [23:0] rgb;
  logic [7:0]  bright;
  logic [15:0] prod;
  logic [7:0]  x;
  logic [7:0]  q;
  logic [16:0] t;

  assign x = (chan == 2'd0) ? rgb[23:16] : (chan == 2'd1) ? rgb[15:8] : rgb[7:0];

  // p/255 = (p + (p>>8) + 1) >> 8 for p < 65535
  assign t = 17'(prod) + 17'(prod[15:8]) + 17'd1;
  assign q = t[15:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      chan <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        chan   <= '0;
        rgb    <= req.rgb;
        bright <= req.bright;
      end else if (busy) begin
        prod <= 16'(x) * 16'(bright);
        chan <= chan + 2'd1;
        if (chan != 2'd0) begin
          case (chan)
            2'd1: result[23:16] <= q;
            2'd2: result[15:8] <= q;
            default: result[7:0] <= q;
          endcase
        end
        if (chan == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/led_effect_frame_encoder_top.sv
// Top level: effect sequencer, APB registers and frame output for the LED encoder.
//
//  channel | dir | handshake       | contents
//  s_axis  | in  | tvalid/tready   | now_ms, restart (tuser)
//  m_axis  | out | tvalid/tready   | pixel words, tlast on last pixel
//  apb     | in  | psel/penable    | five config registers at 4*i
//
// Flow: a restart word is taken in idle; a word that is not due goes to evaluation
// and back to idle. A due frame is evaluated once, then each pixel gets one pass of
// the shared 8x8 scaler over three channels plus start and output.
// Breath adds one scaler pass per frame; rainbow adds one subtract per hue step,
// fewer than 256 per frame.
// Reset: synchronous, returns registers and effect state to defaults.
// Stalls: output register holds a word until taken; s_tready low while busy.
module led_effect_frame_encoder_top
  import lefe_pkg::*;
#(
  parameter int MAX_LEDS = MaxLedsDef
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // now_ms [31:0]
  input  logic        s_tuser,   // restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // pixel_index[5:0], spi_green, spi_red, spi_blue, pad
  output logic        m_tlast,   // frame_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_PIX, S_SC1, S_SC2, S_OUT} state_t;

  state_t      state;
  logic [2:0]  effect_mode;
  logic [23:0] effect_color;
  logic [31:0] step_interval_ms;
  logic [6:0]  strip_length;
  logic [7:0]  global_brightness;

  logic [31:0] now;
  logic [31:0] last_step_time;
  logic [5:0]  wipe_position;
  logic [7:0]  rainbow_offset;
  logic [1:0]  phase_count;
  logic [7:0]  breath_level;
  logic        breath_rising;

  logic [2:0]  mode_lat;
  logic [1:0]  phase_lat;
  logic [5:0]  wipe_lat;
  logic [7:0]  offset_lat;
  logic [23:0] breath_rgb;
  logic [6:0]  n;
  logic [6:0]  idx;
  logic [1:0]  mod3;
  logic [7:0]  hue;      // i*256/n tracked by accumulation
  logic [23:0] pix;

  scale_req_t  req;
  logic        sc_done;
  logic [23:0] sc_res;

  lefe_scale u_scale (.clk(clk), .rst(rst), .req(req), .done(sc_done), .result(sc_res));

  logic [6:0]  n_eff;
  logic [31:0] step_eff;
  logic        wr;

  assign n_eff = (strip_length == 7'd0) ? 7'd1 :
                 (strip_length > 7'(MAX_LEDS)) ? 7'(MAX_LEDS) : strip_length;
  assign step_eff = (step_interval_ms == 32'd0) ? 32'd1 : step_interval_ms;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    case (paddr[4:2])
      RegMode:   prdata = 32'(effect_mode);
      RegColor:  prdata = 32'(effect_color);
      RegStep:   prdata = step_interval_ms;
      RegLength: prdata = 32'(strip_length);
      RegBright: prdata = 32'(global_brightness);
      default:   prdata = '0;
    endcase
  end

  // pixel colour before global brightness
  always_comb begin
    case (mode_lat)
      ModeBlink:   pix = (phase_lat == 2'd0) ? effect_color : 24'd0;
      ModeWipe:    pix = (idx <= 7'(wipe_lat)) ? effect_color : 24'd0;
      ModeBreath:  pix = breath_rgb;
      ModeRainbow: pix = wheel(hue + offset_lat);
      ModeChase:   pix = (idx >= 7'(phase_lat) && mod3 == phase_lat) ? effect_color : 24'd0;
      default:     pix = 24'd0;
    endcase
  end

  // running remainder of i*256 over n; hue steps by one per subtract
  logic [15:0] acc;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      effect_mode <= '0; effect_color <= '0; step_interval_ms <= 32'd1;
      strip_length <= 7'd1; global_brightness <= 8'd255;
      last_step_time <= '0; wipe_position <= '0; rainbow_offset <= '0;
      phase_count <= '0; breath_level <= '0; breath_rising <= 1'b1;
      m_tvalid <= 1'b0;
      req.start <= 1'b0;
    end else begin
      if (wr) begin
        case (paddr[4:2])
          RegMode:   effect_mode <= pwdata[2:0];
          RegColor:  effect_color <= pwdata[23:0];
          RegStep:   step_interval_ms <= pwdata;
          RegLength: strip_length <= pwdata[6:0];
          RegBright: global_brightness <= pwdata[7:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_tvalid) begin
          now <= s_tdata;
          if (s_tuser) begin
            last_step_time <= s_tdata; wipe_position <= '0; rainbow_offset <= '0;
            phase_count <= '0; breath_level <= '0; breath_rising <= 1'b1;
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if ((now - last_step_time) >= step_eff) begin
            last_step_time <= now;
            mode_lat <= effect_mode; phase_lat <= phase_count;
            wipe_lat <= wipe_position; offset_lat <= rainbow_offset;
            n <= n_eff; idx <= '0; mod3 <= '0; hue <= '0;
            acc <= '0;
            case (effect_mode)
              ModeBlink: begin
                phase_count <= (phase_count == 2'd0) ? 2'd1 : 2'd0;
                state <= S_PIX;
              end
              ModeWipe: begin
                wipe_position <= (7'(wipe_position) + 7'd1 >= n_eff) ? 6'd0 : wipe_position + 6'd1;
                state <= S_PIX;
              end
              ModeBreath: begin
                if (breath_rising) begin
                  if (breath_level >= 8'd250) begin
                    breath_level <= 8'd255; breath_rising <= 1'b0;
                  end else breath_level <= breath_level + 8'd5;
                end else begin
                  if (breath_level <= 8'd5) begin
                    breath_level <= 8'd0; breath_rising <= 1'b1;
                  end else breath_level <= breath_level - 8'd5;
                end
                req.start <= 1'b1; req.rgb <= effect_color; req.bright <= breath_level;
                state <= S_SC1;
              end
              ModeRainbow: begin
                rainbow_offset <= rainbow_offset + 8'd1;
                state <= S_PIX;
              end
              ModeChase: begin
                phase_count <= (phase_count >= 2'd2) ? 2'd0 : phase_count + 2'd1;
                state <= S_PIX;
              end
              default: state <= S_IDLE;
            endcase
          end else begin
            state <= S_IDLE;
          end
        end
        S_SC1: begin
          req.start <= 1'b0;
          if (sc_done) begin
            breath_rgb <= sc_res;
            state <= S_PIX;
          end
        end
        S_PIX: begin
          // rainbow: hue = acc / n by repeated subtract, one compare a cycle
          if (mode_lat == ModeRainbow && acc >= 16'(n)) begin
            acc <= acc - 16'(n);
            hue <= hue + 8'd1;
          end else if (!m_tvalid || m_tready) begin
            req.start <= 1'b1; req.rgb <= pix; req.bright <= global_brightness;
            state <= S_SC2;
          end
        end
        S_SC2: begin
          req.start <= 1'b0;
          if (sc_done) begin
            m_tdata <= {2'b0, encode_byte(sc_res[7:0]), encode_byte(sc_res[23:16]),
                        encode_byte(sc_res[15:8]), idx[5:0]};
            m_tlast <= (idx + 7'd1 == n);
            m_tvalid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (idx + 7'd1 == n) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + 7'd1;
            mod3 <= (mod3 == 2'd2) ? 2'd0 : mod3 + 2'd1;
            // acc holds the remainder; next pixel adds another 256
            acc <= acc + 16'd256;
            state <= S_PIX;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(state == S_PIX || state == S_SC2)) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("word changed while stalled");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (idx < n)) else $error("index past strip");

endmodule

FILE: dv/lefe_frame_checker.sv
// Frame checker: tracks register writes, predicts each pixel word, compares the output stream.
`timescale 1ns / 1ps
module lefe_frame_checker
  import lefe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending,
  output int          frames_seen
);

  typedef struct packed {
    logic [5:0]  idx;
    logic [23:0] grn;
    logic [23:0] red;
    logic [23:0] blu;
    logic        last;
  } pixel_word_t;

  pixel_word_t pixel_q[$];

  // register copies
  logic [2:0]  mode;
  logic [23:0] color;
  logic [31:0] step_ms;
  logic [6:0]  length;
  logic [7:0]  bright;

  // effect state
  logic [31:0] last_step;
  int          wipe_pos;
  logic [7:0]  rb_off;
  int          phase;
  int          breath;
  logic        rising;

  function automatic logic [7:0] dim8(input logic [7:0] x, input logic [7:0] b);
    return 8'((16'(x) * 16'(b)) / 16'd255);
  endfunction

  function automatic logic [23:0] dim_rgb(input logic [23:0] c, input logic [7:0] b);
    return {dim8(c[23:16], b), dim8(c[15:8], b), dim8(c[7:0], b)};
  endfunction

  function automatic logic [23:0] line_bits(input logic [7:0] v);
    logic [23:0] acc;
    acc = '0;
    for (int k = 7; k >= 0; k--) acc = {acc[20:0], v[k] ? CodeOne : CodeZero};
    return acc;
  endfunction

  function automatic logic [23:0] hue_rgb(input int pos);
    int p;
    p = 255 - (pos & 255);
    if (p < 85) return {8'(255 - 3 * p), 8'd0, 8'(3 * p)};
    if (p < 170) begin
      p -= 85;
      return {8'd0, 8'(3 * p), 8'(255 - 3 * p)};
    end
    p -= 170;
    return {8'(3 * p), 8'(255 - 3 * p), 8'd0};
  endfunction

  task automatic predict_frame(input logic [31:0] now, input logic restart);
    logic [31:0] step;
    int          n;
    logic [23:0] px [64];
    logic [23:0] c;
    pixel_word_t w;
    step = (step_ms == 0) ? 32'd1 : step_ms;
    n = (length == 0) ? 1 : (length > 64) ? 64 : int'(length);
    if (restart) begin
      last_step = now;
      wipe_pos = 0;
      rb_off = 0;
      phase = 0;
      breath = 0;
      rising = 1'b1;
      return;
    end
    if (32'(now - last_step) < step) return;
    last_step = now;
    case (mode)
      ModeBlink: begin
        for (int i = 0; i < n; i++) px[i] = (phase == 0) ? color : 24'd0;
        phase = (phase == 0) ? 1 : 0;
      end
      ModeWipe: begin
        for (int i = 0; i < n; i++) px[i] = (i <= wipe_pos) ? color : 24'd0;
        wipe_pos++;
        if (wipe_pos >= n) wipe_pos = 0;
      end
      ModeBreath: begin
        c = dim_rgb(color, 8'(breath));
        for (int i = 0; i < n; i++) px[i] = c;
        if (rising) begin
          if (breath >= 250) begin
            breath = 255;
            rising = 1'b0;
          end else breath += 5;
        end else begin
          if (breath <= 5) begin
            breath = 0;
            rising = 1'b1;
          end else breath -= 5;
        end
      end
      ModeRainbow: begin
        for (int i = 0; i < n; i++) px[i] = hue_rgb((i * 256) / n + int'(rb_off));
        rb_off++;
      end
      ModeChase: begin
        for (int i = 0; i < n; i++)
          px[i] = (i >= phase && (i - phase) % 3 == 0) ? color : 24'd0;
        phase++;
        if (phase >= 3) phase = 0;
      end
      default: return;
    endcase
    for (int i = 0; i < n; i++) begin
      c = dim_rgb(px[i], bright);
      w.idx  = 6'(i);
      w.grn  = line_bits(c[15:8]);
      w.red  = line_bits(c[23:16]);
      w.blu  = line_bits(c[7:0]);
      w.last = (i + 1 == n);
      pixel_q.push_back(w);
    end
  endtask

  task automatic check_word();
    pixel_word_t e;
    if (pixel_q.size() == 0) begin
      $error("unexpected pixel word %h last %b", m_tdata, m_tlast);
      fail_count++;
      return;
    end
    e = pixel_q.pop_front();
    if (m_tdata[5:0] !== e.idx) begin
      $error("pixel_index exp %0d got %0d", e.idx, m_tdata[5:0]);
      fail_count++;
    end
    if (m_tdata[29:6] !== e.grn) begin
      $error("spi_green exp %h got %h", e.grn, m_tdata[29:6]);
      fail_count++;
    end
    if (m_tdata[53:30] !== e.red) begin
      $error("spi_red exp %h got %h", e.red, m_tdata[53:30]);
      fail_count++;
    end
    if (m_tdata[77:54] !== e.blu) begin
      $error("spi_blue exp %h got %h", e.blu, m_tdata[77:54]);
      fail_count++;
    end
    if (m_tlast !== e.last) begin
      $error("frame_last exp %b got %b", e.last, m_tlast);
      fail_count++;
    end
    if (e.last) frames_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode = 3'd0; color = '0; step_ms = 32'd1; length = 7'd1; bright = 8'd255;
      last_step = '0; wipe_pos = 0; rb_off = '0; phase = 0; breath = 0; rising = 1'b1;
      fail_count = 0; frames_seen = 0;
      pixel_q.delete();
    end else begin
      if (m_tvalid && m_tready) check_word();
      if (psel && penable && pwrite && pready) begin
        case (3'(paddr >> 2))
          RegMode:   mode = pwdata[2:0];
          RegColor:  color = pwdata[23:0];
          RegStep:   step_ms = pwdata;
          RegLength: length = pwdata[6:0];
          RegBright: bright = pwdata[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_frame(s_tdata, s_tuser);
    end
    pending = pixel_q.size();
  end

endmodule

FILE: dv/tb_led_effect_frame_encoder_top.sv
// Testbench top: stimulus, register phases, stall patterns and verdict for the LED encoder.
`timescale 1ns / 1ps
module tb_led_effect_frame_encoder_top;
  import lefe_pkg::*;

  // mode codes with no effect behind them
  localparam logic [2:0] ModeNone   = 3'd0;
  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;
  localparam int ItemTarget = 500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // now_ms [31:0]
  logic        s_tuser = 1'b0; // restart
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // pixel_index, spi_green, spi_red, spi_blue, pad
  logic        m_tlast;        // frame_last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending, frames_seen;
  int items_sent = 0;
  bit quiet = 1'b0;            // no idling on either side in the closing phases

  // current settings, mirrored here to shape the time stamps
  logic [31:0] cur_step;
  logic [31:0] now_ms;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  led_effect_frame_encoder_top dut (.*);

  lefe_frame_checker u_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending, .frames_seen
  );

  // receiver: ready drops in random bursts
  int hold_cnt = 0;
  always @(negedge clk) begin
    if (rst || quiet) begin
      m_tready <= 1'b1;
      hold_cnt = 0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= (hold_cnt == 0);
    end else if ($urandom_range(0, 9) == 0) begin
      hold_cnt = $urandom_range(1, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_effect(input logic [2:0] mode, input logic [23:0] color,
                            input logic [31:0] step, input logic [6:0] len,
                            input logic [7:0] bright);
    reg_write(RegMode, 32'(mode));
    reg_write(RegColor, 32'(color));
    reg_write(RegStep, step);
    reg_write(RegLength, 32'(len));
    reg_write(RegBright, 32'(bright));
    cur_step = (step == 0) ? 32'd1 : step;
  endtask

  // one time-stamp word; valid may drop before it, but never in the quiet phases
  task automatic send_time(input logic [31:0] t, input logic restart);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid <= 1'b1; s_tdata <= t; s_tuser <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // a run of time stamps, mostly due, some early, a few restarts
  task automatic run_times(input int count);
    logic [31:0] delta;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: delta = 32'($urandom_range(0, 3));
        1: delta = cur_step - 32'd1;
        2: delta = $urandom;
        default: delta = cur_step + 32'($urandom_range(0, 2));
      endcase
      now_ms += delta;
      send_time(now_ms, $urandom_range(0, 11) == 0);
    end
  endtask

  // wait until the frame queue drains, then let a no-result word finish
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic random_phase();
    logic [2:0] mode;
    logic [6:0] len;
    logic [31:0] step;
    case ($urandom_range(0, 9))
      0: mode = ModeNone;
      1: mode = ($urandom_range(0, 1) != 0) ? ModeSpare6 : ModeSpare7;
      default: mode = 3'($urandom_range(1, 5));
    endcase
    case ($urandom_range(0, 9))
      0: len = 7'd64;
      1: len = 7'($urandom_range(65, 127));
      2: len = 7'd0;
      default: len = 7'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 3))
      0: step = $urandom;
      1: step = 32'd0;
      default: step = 32'($urandom_range(1, 40));
    endcase
    set_effect(mode, 24'($urandom), step, len, 8'($urandom));
    now_ms = $urandom;
    if ($urandom_range(0, 2) != 0) send_time(now_ms, 1'b1);
    run_times($urandom_range(15, 30));
    settle();
  endtask

  initial begin
    cur_step = 32'd1;
    now_ms = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings, all extremes of fields, every effect
    send_time(32'd0, 1'b0);
    send_time(32'd1, 1'b0);
    settle();
    set_effect(ModeNone, 24'h000000, 32'd0, 7'd0, 8'd0);
    send_time(32'hFFFF_FFFF, 1'b1);
    send_time(32'h0000_0000, 1'b0);
    settle();
    set_effect(ModeBlink, 24'hFFFFFF, 32'hFFFF_FFFF, 7'd64, 8'd255);
    send_time(32'h8000_0000, 1'b1);
    send_time(32'h7FFF_FFFF, 1'b0);
    send_time(32'h7FFF_FFFE, 1'b0);
    settle();
    // wipe without restart, then shrink so the position lies past the strip
    set_effect(ModeWipe, 24'hA5C3F0, 32'd1, 7'd6, 8'd128);
    now_ms = 32'd100;
    run_times(5);
    settle();
    set_effect(ModeWipe, 24'h5A3C0F, 32'd1, 7'd2, 8'd255);
    run_times(3);
    settle();
    set_effect(ModeRainbow, 24'h000000, 32'd2, 7'd127, 8'd255);
    run_times(2);
    settle();
    set_effect(ModeChase, 24'h123456, 32'd3, 7'd7, 8'd200);
    run_times(3);
    settle();
    set_effect(ModeSpare7, 24'hFFFFFF, 32'd1, 7'd3, 8'd255);
    run_times(2);
    settle();

    // breath across both turning points, one LED to keep it short
    set_effect(ModeBreath, 24'hFFFFFF, 32'd1, 7'd1, 8'd255);
    send_time(now_ms, 1'b1);
    for (int k = 0; k < 110; k++) begin
      now_ms += 32'd1;
      send_time(now_ms, 1'b0);
    end
    settle();

    while (items_sent < ItemTarget) begin
      if (items_sent > ItemTarget - 60) quiet = 1'b1;
      random_phase();
    end

    s_tvalid <= 1'b0;
    repeat (40) @(negedge clk);
    $display("Sent %0d time words; %0d frames checked across all effects and settings.",
             items_sent, frames_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_led_effect_frame_encoder_top passed");
    end else begin
      if (pending != 0) $error("%0d pixel words never arrived", pending);
      $display("tb_led_effect_frame_encoder_top failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("tb_led_effect_frame_encoder_top failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/lefe_pkg.sv
rtl/core/lefe_scale.sv
rtl/core/led_effect_frame_encoder_top.sv
dv/lefe_frame_checker.sv
dv/tb_led_effect_frame_encoder_top.sv
